/* rtl/core/kpc_pkg.sv */
// ----------------------------------------------------------------------------
// kpc_pkg
// shared types, constants and the key map of the keypad press classifier
// ----------------------------------------------------------------------------
package kpc_pkg;

  localparam int unsigned NumKeys   = 16;
  localparam int unsigned KeyIdxW   = 4;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CharW     = 7;
  localparam int unsigned CfgIdxW   = 1;

  // register reset values
  localparam logic [CfgW-1:0] LongPressReset = 16'd1000;
  localparam logic [CfgW-1:0] MinPressReset  = 16'd20;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegLongPress = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMinPress  = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_kind_e;

  // press tracking state, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HELD = 2'b10
  } hold_state_e;

  typedef struct packed {
    logic               found;
    logic [KeyIdxW-1:0] idx;
  } key_hit_t;

  typedef struct packed {
    event_kind_e        kind;
    logic [KeyIdxW-1:0] idx;
    logic [CharW-1:0]   chr;
  } result_t;

  // fixed 4x4 map: 123A / 456B / 789C / *0#D
  function automatic logic [CharW-1:0] key_glyph_of(input logic [KeyIdxW-1:0] idx);
    logic [CharW-1:0] c;
    unique case (idx)
      4'd0:    c = 7'h31; // '1'
      4'd1:    c = 7'h32; // '2'
      4'd2:    c = 7'h33; // '3'
      4'd3:    c = 7'h41; // 'A'
      4'd4:    c = 7'h34; // '4'
      4'd5:    c = 7'h35; // '5'
      4'd6:    c = 7'h36; // '6'
      4'd7:    c = 7'h42; // 'B'
      4'd8:    c = 7'h37; // '7'
      4'd9:    c = 7'h38; // '8'
      4'd10:   c = 7'h39; // '9'
      4'd11:   c = 7'h43; // 'C'
      4'd12:   c = 7'h2A; // '*'
      4'd13:   c = 7'h30; // '0'
      4'd14:   c = 7'h23; // '#'
      default: c = 7'h44; // 'D'
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/kpc_if.sv */
// ----------------------------------------------------------------------------
// kpc_in_if / kpc_out_if
// valid/ready channels for polls and classified events
// ----------------------------------------------------------------------------
interface kpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [kpc_pkg::TimeW-1:0]    now_ms;
  logic [kpc_pkg::NumKeys-1:0]  key_lines;

  modport source (output valid, output now_ms, output key_lines, input ready);
  modport sink   (input valid, input now_ms, input key_lines, output ready);
endinterface

interface kpc_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   event_kind;
  logic [kpc_pkg::KeyIdxW-1:0]  key_index;
  logic [kpc_pkg::CharW-1:0]    key_glyph;

  modport source (output valid, output event_kind, output key_index, output key_glyph,
                  input ready);
  modport sink   (input valid, input event_kind, input key_index, input key_glyph,
                  output ready);
endinterface

/* rtl/core/kpc_key_find.sv */
// ----------------------------------------------------------------------------
// kpc_key_find
// priority encoder: first low key line in row-major order
// ----------------------------------------------------------------------------
module kpc_key_find (
  input  logic [kpc_pkg::NumKeys-1:0] key_lines_i,
  output kpc_pkg::key_hit_t           hit_o
);

  always_comb begin
    hit_o.found = 1'b0;
    hit_o.idx   = '0;
    for (int i = kpc_pkg::NumKeys - 1; i >= 0; i--) begin
      if (!key_lines_i[i]) begin
        hit_o.found = 1'b1;
        hit_o.idx   = kpc_pkg::KeyIdxW'(i);
      end
    end
  end

endmodule

/* rtl/core/kpc_event_fsm.sv */
// ----------------------------------------------------------------------------
// kpc_event_fsm
// press tracking state and short/long event decision for one poll
// ----------------------------------------------------------------------------
module kpc_event_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [kpc_pkg::TimeW-1:0]     now_ms_i,
  input  kpc_pkg::key_hit_t             hit_i,
  input  logic [kpc_pkg::CfgW-1:0]      long_press_ms_i,
  input  logic [kpc_pkg::CfgW-1:0]      min_press_ms_i,
  output kpc_pkg::result_t              res_o
);

  kpc_pkg::hold_state_e          state_q, state_d;
  logic [kpc_pkg::KeyIdxW-1:0]   held_key_q, held_key_d;
  logic [kpc_pkg::TimeW-1:0]     press_start_q, press_start_d;
  logic [kpc_pkg::TimeW-1:0]     elapsed;
  logic                          long_due, min_met;
  kpc_pkg::event_kind_e          kind;

  // elapsed time wraps modulo 2^32
  assign elapsed  = now_ms_i - press_start_q;
  assign long_due = elapsed >= {{(kpc_pkg::TimeW-kpc_pkg::CfgW){1'b0}}, long_press_ms_i};
  assign min_met  = elapsed >= {{(kpc_pkg::TimeW-kpc_pkg::CfgW){1'b0}}, min_press_ms_i};

  always_comb begin
    state_d       = state_q;
    held_key_d    = held_key_q;
    press_start_d = press_start_q;
    kind          = kpc_pkg::EV_NONE;
    unique case (state_q)
      kpc_pkg::ST_IDLE: begin
        if (hit_i.found) begin
          state_d       = kpc_pkg::ST_HELD;
          held_key_d    = hit_i.idx;
          press_start_d = now_ms_i;
        end
      end
      kpc_pkg::ST_HELD: begin
        if (hit_i.found) begin
          // another key while held is ignored
          if (hit_i.idx == held_key_q && long_due) begin
            kind    = kpc_pkg::EV_LONG;
            state_d = kpc_pkg::ST_IDLE;
          end
        end else begin
          state_d = kpc_pkg::ST_IDLE;
          if (min_met) begin
            kind = kpc_pkg::EV_SHORT;
          end
        end
      end
      default: begin
        state_d = kpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.kind = kind;
    if (kind == kpc_pkg::EV_NONE) begin
      res_o.idx = '0;
      res_o.chr = '0;
    end else begin
      res_o.idx = held_key_q;
      res_o.chr = kpc_pkg::key_glyph_of(held_key_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= kpc_pkg::ST_IDLE;
      held_key_q    <= '0;
      press_start_q <= '0;
    end else if (step_i) begin
      state_q       <= state_d;
      held_key_q    <= held_key_d;
      press_start_q <= press_start_d;
    end
  end

endmodule

/* rtl/core/matrix_keypad_press_classifier.sv */
// ----------------------------------------------------------------------------
// matrix_keypad_press_classifier
// 4x4 keypad poll classifier producing short and long press events
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  in_if     in   valid/ready    now_ms[31:0], key_lines[15:0]
//  out_if    out  valid/ready    event_kind[1:0], key_index[3:0], key_glyph[6:0]
//  cfg       in   cfg_we_i       cfg_idx_i (0 long_press_ms, 1 min_press_ms), cfg_wdata_i
//
//  one poll per cycle sustained while the output is not stalled, one result per poll
//  a poll waits in the poll register; the subtract and compare against the press
//  start then load the result register once the result slot is empty or being
//  emptied, so a result is valid only after it has passed both registers
//  reset clears both valid flags and the press state and loads the register defaults
//  a stalled output holds its result; the input stalls once one more poll is waiting
//
module matrix_keypad_press_classifier (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kpc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [kpc_pkg::CfgW-1:0]          cfg_wdata_i,
  kpc_in_if.sink                            in_if,
  kpc_out_if.source                         out_if
);

  // configuration registers
  logic [kpc_pkg::CfgW-1:0] long_press_q;
  logic [kpc_pkg::CfgW-1:0] min_press_q;

  // poll register
  logic                         in_vld_q, in_vld_d;
  logic [kpc_pkg::TimeW-1:0]    now_q;
  logic [kpc_pkg::NumKeys-1:0]  lines_q;

  // result register
  logic                         out_vld_q, out_vld_d;
  kpc_pkg::result_t             res_q;

  logic                         in_take;
  logic                         advance;
  kpc_pkg::key_hit_t            hit;
  kpc_pkg::result_t             res;

  // poll moves on when the result slot is empty or being emptied
  assign advance      = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready  = !in_vld_q || advance;
  assign in_take      = in_if.valid && in_if.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_if.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= kpc_pkg::LongPressReset;
      min_press_q  <= kpc_pkg::MinPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kpc_pkg::RegLongPress: long_press_q <= cfg_wdata_i;
        kpc_pkg::RegMinPress:  min_press_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q   <= in_if.now_ms;
      lines_q <= in_if.key_lines;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  kpc_key_find u_key_find (
    .key_lines_i (lines_q),
    .hit_o       (hit)
  );

  // press state advances exactly once per poll, in poll order
  kpc_event_fsm u_event_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .now_ms_i        (now_q),
    .hit_i           (hit),
    .long_press_ms_i (long_press_q),
    .min_press_ms_i  (min_press_q),
    .res_o           (res)
  );

  assign out_if.valid      = out_vld_q;
  assign out_if.event_kind = res_q.kind;
  assign out_if.key_index  = res_q.idx;
  assign out_if.key_glyph  = res_q.chr;

endmodule

/* rtl/core/kpc_checker.sv */
// ----------------------------------------------------------------------------
// kpc_checker
// port level checks on the classifier result channel
// ----------------------------------------------------------------------------
module kpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    event_kind,
  input logic [kpc_pkg::KeyIdxW-1:0]   key_index,
  input logic [kpc_pkg::CharW-1:0]     key_glyph
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(key_index))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> event_kind == kpc_pkg::EV_NONE || event_kind == kpc_pkg::EV_SHORT ||
                  event_kind == kpc_pkg::EV_LONG)
    else $error("illegal event kind");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && event_kind == kpc_pkg::EV_NONE |-> key_index == '0 && key_glyph == '0)
    else $error("no-event result carries a key");

  a_char_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && event_kind != kpc_pkg::EV_NONE |->
      key_glyph == kpc_pkg::key_glyph_of(key_index))
    else $error("key character does not match key index");

endmodule

bind matrix_keypad_press_classifier kpc_checker u_kpc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .event_kind (out_if.event_kind),
  .key_index  (out_if.key_index),
  .key_glyph  (out_if.key_glyph)
);

/* verif/kpc_press_checker.sv */
// ----------------------------------------------------------------------------
// kpc_press_checker
// watches the poll and event channels, predicts each event and compares it
// ----------------------------------------------------------------------------
module kpc_press_checker
  import kpc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               poll_valid_i,
  input  logic               poll_ready_i,
  input  logic [TimeW-1:0]   now_ms_i,
  input  logic [NumKeys-1:0] key_lines_i,
  input  logic               event_valid_i,
  input  logic               event_ready_i,
  input  logic [1:0]         event_kind_i,
  input  logic [KeyIdxW-1:0] key_index_i,
  input  logic [CharW-1:0]   key_glyph_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  // key legend, first character belongs to key 0
  localparam logic [8*NumKeys-1:0] KeyLegend = "123A456B789C*0#D";

  logic [CfgW-1:0]    long_ms_q;
  logic [CfgW-1:0]    min_ms_q;
  logic               timing_q;
  logic [KeyIdxW-1:0] timed_key_q;
  logic [TimeW-1:0]   press_t0_q;
  result_t            events_due_q[$];

  function automatic key_hit_t lowest_down(input logic [NumKeys-1:0] lines);
    key_hit_t hit;
    hit = '0;
    for (int i = NumKeys - 1; i >= 0; i--) begin
      if (!lines[i]) begin
        hit.found = 1'b1;
        hit.idx   = KeyIdxW'(i);
      end
    end
    return hit;
  endfunction

  // advances the press tracking by one poll and returns the event it yields
  function automatic result_t classify_poll(input logic [TimeW-1:0]   now,
                                            input logic [NumKeys-1:0] lines);
    key_hit_t         hit;
    logic [TimeW-1:0] held_for;
    result_t          ev;
    hit      = lowest_down(lines);
    held_for = now - press_t0_q;
    ev.kind  = EV_NONE;
    ev.idx   = '0;
    ev.chr   = '0;
    if (hit.found) begin
      if (!timing_q) begin
        timing_q    = 1'b1;
        timed_key_q = hit.idx;
        press_t0_q  = now;
      end else if (hit.idx == timed_key_q && held_for >= TimeW'(long_ms_q)) begin
        ev.kind  = EV_LONG;
        ev.idx   = timed_key_q;
        timing_q = 1'b0;
      end
    end else if (timing_q) begin
      timing_q = 1'b0;
      if (held_for >= TimeW'(min_ms_q)) begin
        ev.kind = EV_SHORT;
        ev.idx  = timed_key_q;
      end
    end
    if (ev.kind != EV_NONE) begin
      ev.chr = KeyLegend[8*(NumKeys - 1 - int'(ev.idx)) +: CharW];
    end
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    if (!rst_ni) begin
      long_ms_q   = LongPressReset;
      min_ms_q    = MinPressReset;
      timing_q    = 1'b0;
      timed_key_q = '0;
      press_t0_q  = '0;
      events_due_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLongPress: long_ms_q = cfg_wdata_i;
          RegMinPress:  min_ms_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (event_valid_i && event_ready_i) begin
        if (events_due_q.size() == 0) begin
          $display("%0t: unexpected event kind %0d key %0d char 0x%02h", $time,
                   event_kind_i, key_index_i, key_glyph_i);
          fail_count_o++;
        end else begin
          due = events_due_q.pop_front();
          if (event_kind_i !== due.kind) begin
            $display("%0t: event_kind expected %0d, got %0d", $time, due.kind,
                     event_kind_i);
            fail_count_o++;
          end
          if (key_index_i !== due.idx) begin
            $display("%0t: key_index expected %0d, got %0d", $time, due.idx,
                     key_index_i);
            fail_count_o++;
          end
          if (key_glyph_i !== due.chr) begin
            $display("%0t: key_glyph expected 0x%02h, got 0x%02h", $time, due.chr,
                     key_glyph_i);
            fail_count_o++;
          end
        end
      end
      if (poll_valid_i && poll_ready_i) begin
        events_due_q.push_back(classify_poll(now_ms_i, key_lines_i));
      end
    end
    pending_o = events_due_q.size();
  end

endmodule

/* verif/tb_matrix_keypad_press_classifier.sv */
// ----------------------------------------------------------------------------
// tb_matrix_keypad_press_classifier
// drives keypad polls through the press classifier under random back-pressure
// and several register settings; a checker beside the block predicts every
// event and reports mismatches, the verdict comes from its failure count
// ----------------------------------------------------------------------------
module tb_matrix_keypad_press_classifier;
  import kpc_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  int unsigned        fail_count;
  int unsigned        pending;

  kpc_in_if  poll_if ();
  kpc_out_if event_if ();

  // stimulus-side copy of the limits, only used to shape press durations
  int unsigned        cur_long;
  int unsigned        cur_min;
  logic [TimeW-1:0]   wall_ms;
  int unsigned        polls_sent;

  // idling control shared between the sender and the receiver
  bit                 steady;
  int unsigned        hold_requests;
  int unsigned        hold_served;
  int unsigned        hold_left;

  always #2 clk_i = ~clk_i;

  matrix_keypad_press_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (poll_if),
    .out_if      (event_if)
  );

  kpc_press_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .poll_valid_i  (poll_if.valid),
    .poll_ready_i  (poll_if.ready),
    .now_ms_i      (poll_if.now_ms),
    .key_lines_i   (poll_if.key_lines),
    .event_valid_i (event_if.valid),
    .event_ready_i (event_if.ready),
    .event_kind_i  (event_if.event_kind),
    .key_index_i   (event_if.key_index),
    .key_glyph_i   (event_if.key_glyph),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // event receiver: random stalls, a steady stretch, and long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = 48;
    end
    if (hold_left > 0) begin
      hold_left--;
      event_if.ready <= 1'b0;
    end else if (steady) begin
      event_if.ready <= 1'b1;
    end else begin
      event_if.ready <= ($urandom_range(99) >= 36);
    end
  end

  // offer one poll and hold it until the block takes the transaction
  task automatic put_poll(input logic [TimeW-1:0] now, input logic [NumKeys-1:0] lines);
    @(negedge clk_i);
    poll_if.valid     <= 1'b1;
    poll_if.now_ms    <= now;
    poll_if.key_lines <= lines;
    do @(posedge clk_i); while (!poll_if.ready);
    polls_sent++;
  endtask

  // random sender gaps, about a third of the cycles unless in a steady stretch
  task automatic poll_gap();
    while (!steady && $urandom_range(99) < 36) begin
      @(negedge clk_i);
      poll_if.valid <= 1'b0;
    end
  endtask

  // stop offering and wait until every predicted event has come out
  task automatic drain();
    @(negedge clk_i);
    poll_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // registers are only touched with the block idle
  task automatic set_limits(input int unsigned long_ms, input int unsigned min_ms);
    drain();
    write_reg(RegLongPress, CfgW'(long_ms));
    write_reg(RegMinPress, CfgW'(min_ms));
    cur_long = long_ms;
    cur_min  = min_ms;
  endtask

  // key k low, sometimes with further keys low above it (those never win)
  function automatic logic [NumKeys-1:0] key_down_lines(input int unsigned k);
    logic [31:0] lines;
    lines = ~(32'd1 << k);
    if ($urandom_range(1) == 1) begin
      lines &= ~($urandom() & (32'hFFFF << (k + 1)));
    end
    return NumKeys'(lines);
  endfunction

  // mostly the held key again, now and then another key gets in the way
  function automatic logic [NumKeys-1:0] held_lines(input int unsigned k);
    int unsigned other;
    other = $urandom_range(15);
    case ($urandom_range(6))
      0:       return NumKeys'(~(32'd1 << other));
      1:       return NumKeys'(~(32'd1 << other) & ~(32'd1 << k));
      default: return key_down_lines(k);
    endcase
  endfunction

  // one press: key down, a few polls while held, then release; the span is
  // steered around the short and long thresholds
  task automatic press_sequence();
    int unsigned     k;
    int unsigned     holds;
    longint unsigned span;
    logic [TimeW-1:0] t0;
    k = $urandom_range(15);
    case ($urandom_range(3))
      0: span = $urandom_range(0, cur_min + 2);
      1: begin
        span = longint'(cur_long) + $urandom_range(0, 2);
        if (span > 0) span--;
      end
      2: span = $urandom_range(0, 3 * cur_long + 3);
      default: begin
        span = cur_min;
        if ($urandom_range(1) == 1 && span > 0) span--;
      end
    endcase
    holds = $urandom_range(0, 4);
    t0    = wall_ms;
    poll_gap();
    put_poll(t0, key_down_lines(k));
    for (int i = 1; i <= holds; i++) begin
      poll_gap();
      put_poll(t0 + TimeW'(span * i / holds), held_lines(k));
    end
    poll_gap();
    // an occasional press runs straight into the next one with no release
    if ($urandom_range(9) != 0) begin
      put_poll(t0 + TimeW'(span) + ($urandom_range(3) == 0), '1);
    end
    wall_ms = t0 + TimeW'(span) + $urandom_range(1, 40);
  endtask

  // free-form poll: any lines, sometimes a jump of the timestamp either way
  task automatic noise_poll();
    logic [TimeW-1:0] now;
    if ($urandom_range(3) == 0) now = $urandom();
    else now = wall_ms + $urandom_range(0, 100);
    wall_ms = now;
    poll_gap();
    put_poll(now, NumKeys'($urandom()));
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned first;
    first = polls_sent;
    while (polls_sent - first < quota) begin
      if ($urandom_range(4) == 0) noise_poll();
      else press_sequence();
    end
  endtask

  initial begin
    // every block input known from time zero
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = RegLongPress;
    cfg_wdata          = '0;
    poll_if.valid      = 1'b0;
    poll_if.now_ms     = '0;
    poll_if.key_lines  = '1;
    event_if.ready     = 1'b0;
    steady             = 1'b0;
    hold_requests      = 0;
    hold_served        = 0;
    hold_left          = 0;
    polls_sent         = 0;
    cur_long           = LongPressReset;
    cur_min            = MinPressReset;
    wall_ms            = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, default limits of 1000 ms and 20 ms
    put_poll(32'd0, 16'hFFFF);          // nothing pressed, nothing timed
    put_poll(32'd100, 16'hFFFE);        // key 0 down
    put_poll(32'd110, 16'hFFFF);        // release too early for a short press
    put_poll(32'd200, 16'h7FFF);        // top key down
    put_poll(32'd220, 16'hFFFF);        // release right on the minimum
    put_poll(32'd300, 16'h0000);        // every key low, lowest one wins
    put_poll(32'd400, 16'hFFDF);        // other key while held is ignored
    put_poll(32'd1299, 16'h0000);       // one short of the long threshold
    put_poll(32'd1300, 16'h0000);       // long press fires and clears the hold
    put_poll(32'd1301, 16'hFFFE);       // still down, so a fresh press starts
    put_poll(32'd1400, 16'hFFFF);       // short press of the fresh one
    put_poll(32'hFFFF_FFF0, 16'hEFFF);  // press just before the timestamp wraps
    put_poll(32'd16, 16'hFFFF);         // elapsed time taken across the wrap
    put_poll(32'd5000, 16'hFF7F);
    put_poll(32'd4000, 16'hFFFF);       // timestamp ran backwards, huge elapsed

    set_limits(65535, 65535);
    put_poll(32'd0, 16'hFFF7);
    put_poll(32'd65534, 16'hFFF7);
    put_poll(32'd65535, 16'hFFF7);      // long press at the largest limit
    put_poll(32'd70000, 16'hFDFF);
    put_poll(32'd135534, 16'hFFFF);     // release below the largest minimum

    // zero long limit: fires on the first poll after the press
    set_limits(0, 0);
    put_poll(32'd10, 16'hDFFF);
    put_poll(32'd10, 16'hDFFF);
    put_poll(32'd20, 16'hBFFF);
    put_poll(32'd20, 16'hFFFF);

    // random part, one phase per setting
    set_limits(LongPressReset, MinPressReset);
    wall_ms = $urandom();
    random_phase(100);

    // receiver holds off while polls keep coming, so the block backs up
    set_limits(1, 0);
    random_phase(40);
    hold_requests++;
    random_phase(60);

    // sender waits for the block to empty in the middle of a phase
    set_limits(0, 0);
    wall_ms = 32'hFFFF_FF00;
    random_phase(50);
    drain();
    random_phase(50);

    set_limits(65535, 65535);
    wall_ms = $urandom();
    random_phase(100);

    // neither side idles in this stretch
    set_limits($urandom_range(1, 300), $urandom_range(0, 60));
    steady = 1'b1;
    random_phase(100);
    steady = 1'b0;

    set_limits($urandom_range(1, 65535), $urandom_range(0, 65535));
    random_phase(100);

    // let the last events out, then wait for anything stray
    drain();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_matrix_keypad_press_classifier: clean");
    end else begin
      $display("tb_matrix_keypad_press_classifier: errors");
    end
    $finish;
  end

  // overall watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb_matrix_keypad_press_classifier: errors");
    $finish;
  end

endmodule
